### hdl/pms_pkg.sv
// Shared types and constants for the particulate sensor frame parser.
// No dependencies; imported by every module of the block.
package pms_pkg;

    localparam int BYTE_W  = 8;
    localparam int WORD_W  = 16;
    localparam int POS_W   = 17;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_FIRST  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_HEADER_SECOND = 2'd1;

    localparam logic [BYTE_W-1:0] HEADER_FIRST_RST  = 8'h42;
    localparam logic [BYTE_W-1:0] HEADER_SECOND_RST = 8'h4d;

    // Fixed byte slots of a frame.
    localparam logic [POS_W-1:0] POS_HUNT    = 17'd0;
    localparam logic [POS_W-1:0] POS_HDR2    = 17'd1;
    localparam logic [POS_W-1:0] POS_LEN_HI  = 17'd2;
    localparam logic [POS_W-1:0] POS_LEN_LO  = 17'd3;
    localparam logic [POS_W-1:0] POS_WA_HI   = 17'd4;
    localparam logic [POS_W-1:0] POS_WA_LO   = 17'd5;
    localparam logic [POS_W-1:0] POS_DATA    = 17'd6;
    localparam logic [POS_W-1:0] POS_WC_HI   = 17'd8;
    localparam logic [POS_W-1:0] POS_WC_LO   = 17'd9;
    localparam logic [POS_W-1:0] POS_AFTER_WC = 17'd10;
    // Highest position a frame can reach: the last checksum byte at length 65535.
    localparam logic [POS_W-1:0] POS_MAX     = 17'd65538;

    localparam logic FRAME_OK       = 1'b0;
    localparam logic FRAME_MISMATCH = 1'b1;

    typedef struct packed {
        logic [WORD_W-1:0] third_word;
        logic [WORD_W-1:0] first_word;
        logic              frame_status;
    } t_result;

endpackage

### hdl/pms_parser.sv
// Per-byte frame parser: header hunt, length, data words and checksum.
// Depends on pms_pkg; result goes to the output buffer in the same cycle.
module pms_parser (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [pms_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pms_pkg::BYTE_W-1:0]    i_cfg_data,
    input  logic                          i_valid,
    input  logic [pms_pkg::BYTE_W-1:0]    i_rx_byte,
    output logic                          o_res_valid,
    output pms_pkg::t_result              o_res
);
    import pms_pkg::*;

    logic [BYTE_W-1:0] r_hdr_first, r_hdr_second;
    logic [POS_W-1:0]  r_pos, n_pos;
    logic [WORD_W-1:0] r_len, n_len;
    logic [WORD_W-1:0] r_sum, n_sum;
    logic [BYTE_W-1:0] r_rx_hi, n_rx_hi;
    logic [WORD_W-1:0] r_word_a, n_word_a;
    logic [WORD_W-1:0] r_word_c, n_word_c;
    logic [BYTE_W-1:0] r_prev;

    logic              resync;
    logic [POS_W-1:0]  len_p2, len_p3;
    logic [WORD_W-1:0] sum_add;

    assign len_p2  = {1'b0, r_len} + 17'd2;
    assign len_p3  = {1'b0, r_len} + 17'd3;
    assign sum_add = r_sum + {8'h00, i_rx_byte};
    // A header pair seen inside a frame restarts it just past the header.
    assign resync  = (r_pos > POS_LEN_HI) && (r_prev == r_hdr_first)
                     && (i_rx_byte == r_hdr_second);

    always_comb begin
        n_pos       = r_pos;
        n_len       = r_len;
        n_sum       = r_sum;
        n_rx_hi     = r_rx_hi;
        n_word_a    = r_word_a;
        n_word_c    = r_word_c;
        o_res_valid = 1'b0;
        o_res.first_word   = r_word_a;
        o_res.third_word   = r_word_c;
        o_res.frame_status = (r_sum == {r_rx_hi, i_rx_byte}) ? FRAME_OK : FRAME_MISMATCH;
        if (resync) begin
            n_pos = POS_LEN_HI;
            n_sum = {8'h00, r_hdr_first} + {8'h00, r_hdr_second};
        end else begin
            unique case (r_pos)
                POS_HUNT: begin
                    if (i_rx_byte == r_hdr_first) begin
                        n_pos = POS_HDR2;
                        n_sum = {8'h00, i_rx_byte};
                    end
                end
                POS_HDR2: begin
                    if (i_rx_byte == r_hdr_second) begin
                        n_pos = POS_LEN_HI;
                        n_sum = sum_add;
                    end else begin
                        n_pos = POS_HUNT;
                    end
                end
                POS_LEN_HI: begin
                    n_sum = sum_add;
                    n_len = {i_rx_byte, 8'h00};
                    n_pos = POS_LEN_LO;
                end
                POS_LEN_LO: begin
                    n_sum = sum_add;
                    n_len = {r_len[15:8], i_rx_byte};
                    n_pos = POS_WA_HI;
                end
                POS_WA_HI: begin
                    n_sum    = sum_add;
                    n_word_a = {i_rx_byte, 8'h00};
                    n_pos    = POS_WA_LO;
                end
                POS_WA_LO: begin
                    n_sum    = sum_add;
                    n_word_a = {r_word_a[15:8], i_rx_byte};
                    n_pos    = POS_DATA;
                end
                POS_WC_HI: begin
                    n_sum    = sum_add;
                    n_word_c = {i_rx_byte, 8'h00};
                    n_pos    = POS_WC_LO;
                end
                POS_WC_LO: begin
                    n_sum    = sum_add;
                    n_word_c = {r_word_c[15:8], i_rx_byte};
                    n_pos    = POS_AFTER_WC;
                end
                default: begin
                    priority if (r_pos == len_p2) begin
                        n_rx_hi = i_rx_byte;
                        n_pos   = r_pos + 17'd1;
                    end else if (r_pos == len_p3) begin
                        o_res_valid = i_valid;
                        n_pos       = POS_HUNT;
                    end else if (r_pos > len_p3) begin
                        // Frame ran past its length: dropped without a result.
                        n_pos = POS_HUNT;
                    end else begin
                        n_sum = sum_add;
                        n_pos = r_pos + 17'd1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hdr_first  <= HEADER_FIRST_RST;
            r_hdr_second <= HEADER_SECOND_RST;
            r_pos        <= POS_HUNT;
            r_len        <= '0;
            r_sum        <= '0;
            r_rx_hi      <= '0;
            r_word_a     <= '0;
            r_word_c     <= '0;
            r_prev       <= '0;
        end else begin
            if (i_cfg_we && i_cfg_index == CFG_HEADER_FIRST) begin
                r_hdr_first <= i_cfg_data;
            end
            if (i_cfg_we && i_cfg_index == CFG_HEADER_SECOND) begin
                r_hdr_second <= i_cfg_data;
            end
            if (i_valid) begin
                r_pos    <= n_pos;
                r_len    <= n_len;
                r_sum    <= n_sum;
                r_rx_hi  <= n_rx_hi;
                r_word_a <= n_word_a;
                r_word_c <= n_word_c;
                r_prev   <= i_rx_byte;
            end
        end
    end

    a_res_needs_byte: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |-> i_valid)
        else $error("result raised without an accepted byte");
    a_res_restarts_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_valid |=> r_pos == POS_HUNT)
        else $error("parser did not return to hunting after a result");
    a_resync_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && resync) |=> r_pos == POS_LEN_HI)
        else $error("resync did not restart the frame at the length field");
    a_pos_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pos <= POS_MAX)
        else $error("byte position beyond the longest frame");

endmodule

### hdl/pms_out_fifo.sv
// Two-entry result buffer between the parser and the output stream.
// Depends on pms_pkg for the result type.
module pms_out_fifo (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  pms_pkg::t_result i_data,
    output logic             o_has_space,
    output logic             o_valid,
    input  logic             i_ready,
    output pms_pkg::t_result o_data
);
    import pms_pkg::*;

    t_result    r_mem [2];
    logic       r_wr_ptr, r_rd_ptr;
    logic [1:0] r_count;
    logic       pop;

    assign o_valid     = (r_count != 2'd0);
    assign o_has_space = (r_count != 2'd2);
    assign o_data      = r_mem[r_rd_ptr];
    assign pop         = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            unique case ({i_push, pop})
                2'b10:   r_count <= r_count + 2'd1;
                2'b01:   r_count <= r_count - 2'd1;
                default: r_count <= r_count;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> o_has_space)
        else $error("result pushed into a full buffer");
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'd2)
        else $error("buffer count out of range");
    a_ptr_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count == 2'd1) |-> (r_wr_ptr != r_rd_ptr))
        else $error("buffer pointers disagree with the count");

endmodule

### hdl/pms_frame_parser_top.sv
// Top level of the particulate sensor frame parser.
// Instantiates pms_parser and pms_out_fifo; depends on pms_pkg.

// The block takes one received byte per cycle on the slave stream while the output
// buffer has space and parses each byte in that same cycle. A frame's result (both data
// words and the checksum status) is written into a two-entry output buffer when its last
// checksum byte is transferred and is offered on the master stream from there; the input
// stalls only while both buffer entries hold results that have not been taken. Header bytes
// are programmed through the configuration channel, which is always ready; index 0 sets
// the first header byte and index 1 the second.
module pms_frame_parser_top (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [pms_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [pms_pkg::BYTE_W-1:0]    i_cfg_data,
    input  logic                          i_s_axis_tvalid,
    output logic                          o_s_axis_tready,
    input  logic [7:0]                    i_s_axis_tdata,  // [7:0] rx_byte
    output logic                          o_m_axis_tvalid,
    input  logic                          i_m_axis_tready,
    output logic [31:0]                   o_m_axis_tdata,  // [15:0] first_word, [31:16] third_word
    output logic [0:0]                    o_m_axis_tuser   // [0] frame_status
);
    import pms_pkg::*;

    logic    in_xfer;
    logic    res_valid;
    logic    fifo_space;
    t_result res;
    t_result out_res;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = fifo_space;
    assign in_xfer         = i_s_axis_tvalid && fifo_space;

    pms_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (in_xfer),
        .i_rx_byte   (i_s_axis_tdata),
        .o_res_valid (res_valid),
        .o_res       (res)
    );

    pms_out_fifo u_out_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (res_valid),
        .i_data      (res),
        .o_has_space (fifo_space),
        .o_valid     (o_m_axis_tvalid),
        .i_ready     (i_m_axis_tready),
        .o_data      (out_res)
    );

    assign o_m_axis_tdata = {out_res.third_word, out_res.first_word};
    assign o_m_axis_tuser = out_res.frame_status;

endmodule

### tb/pms_frame_parser_top_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for pms_frame_parser_top: byte streams of sensor frames in,
// parsed data words and checksum status out, compared with a local parser model.
// Depends on pms_pkg and the RTL of the block; needs no files or arguments.
module pms_frame_parser_top_test;
    import pms_pkg::*;

    localparam int DRAIN_CYCLES = 8;
    localparam int HOLD_CYCLES  = 300;

    typedef struct packed {
        logic [7:0] rx;
        logic       typed;
        t_result    want;
    } t_row;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = CFG_HEADER_FIRST;
    logic [BYTE_W-1:0]    i_cfg_data = '0;
    logic                 i_s_axis_tvalid = 1'b0;
    logic                 o_s_axis_tready;
    logic [7:0]           i_s_axis_tdata = '0;
    logic                 o_m_axis_tvalid;
    logic                 i_m_axis_tready = 1'b0;
    logic [31:0]          o_m_axis_tdata;
    logic [0:0]           o_m_axis_tuser;

    // Header bytes as the block currently holds them.
    logic [7:0]  cfg_hdr1 = HEADER_FIRST_RST;
    logic [7:0]  cfg_hdr2 = HEADER_SECOND_RST;

    // Parser model state.
    logic [16:0] trk_pos = '0;
    logic [15:0] trk_len = '0;
    logic [15:0] trk_sum = '0;
    logic [15:0] trk_csum = '0;
    logic [15:0] trk_w1 = '0;
    logic [15:0] trk_w3 = '0;
    logic [7:0]  trk_last = '0;

    t_result     pending_frames[$];
    int unsigned bytes_sent = 0;
    int unsigned frames_seen = 0;
    int unsigned err_count = 0;
    int unsigned src_idle_pct = 0;
    int unsigned snk_stall_pct = 0;
    int unsigned hold_ask = 0;
    int unsigned hold_seen = 0;
    int unsigned hold_left = 0;
    t_row        script [0:26];

    pms_frame_parser_top u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    initial begin
        #400us;
        $display("== FAIL ==");
        $finish;
    end

    task automatic note_error(input string msg);
        err_count++;
        if (err_count <= 40) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    // Advances the parser model by one received byte; returns 1 when a frame completes.
    function automatic bit parse_byte(input logic [7:0] b, output t_result r);
        logic [16:0] lenv;
        bit          got;
        lenv = {1'b0, trk_len};
        got  = 1'b0;
        r    = '0;
        // A header pair inside a frame restarts it.
        if (trk_pos > POS_LEN_HI && trk_last == cfg_hdr1 && b == cfg_hdr2) begin
            trk_pos = POS_HDR2;
            trk_sum = {8'h00, cfg_hdr1};
        end
        case (trk_pos)
            POS_HUNT: begin
                if (b == cfg_hdr1) begin
                    trk_pos = POS_HDR2;
                    trk_sum = {8'h00, b};
                end
            end
            POS_HDR2: begin
                if (b == cfg_hdr2) begin
                    trk_pos = POS_LEN_HI;
                    trk_sum = trk_sum + 16'(b);
                end else begin
                    trk_pos = POS_HUNT;
                end
            end
            POS_LEN_HI: begin
                trk_sum = trk_sum + 16'(b);
                trk_len = {b, 8'h00};
                trk_pos = POS_LEN_LO;
            end
            POS_LEN_LO: begin
                trk_sum = trk_sum + 16'(b);
                trk_len = {trk_len[15:8], b};
                trk_pos = POS_WA_HI;
            end
            POS_WA_HI: begin
                trk_sum = trk_sum + 16'(b);
                trk_w1  = {b, 8'h00};
                trk_pos = POS_WA_LO;
            end
            POS_WA_LO: begin
                trk_sum = trk_sum + 16'(b);
                trk_w1  = {trk_w1[15:8], b};
                trk_pos = POS_DATA;
            end
            POS_WC_HI: begin
                trk_sum = trk_sum + 16'(b);
                trk_w3  = {b, 8'h00};
                trk_pos = POS_WC_LO;
            end
            POS_WC_LO: begin
                trk_sum = trk_sum + 16'(b);
                trk_w3  = {trk_w3[15:8], b};
                trk_pos = POS_AFTER_WC;
            end
            default: begin
                if (trk_pos == lenv + 17'd2) begin
                    trk_csum = {b, 8'h00};
                    trk_pos  = trk_pos + 17'd1;
                end else if (trk_pos == lenv + 17'd3) begin
                    trk_csum       = {trk_csum[15:8], b};
                    r.first_word   = trk_w1;
                    r.third_word   = trk_w3;
                    r.frame_status = (trk_sum == trk_csum) ? FRAME_OK : FRAME_MISMATCH;
                    got            = 1'b1;
                    trk_pos        = POS_HUNT;
                end else if (trk_pos > lenv + 17'd3) begin
                    trk_pos = POS_HUNT;
                end else begin
                    trk_sum = trk_sum + 16'(b);
                    trk_pos = trk_pos + 17'd1;
                end
            end
        endcase
        trk_last = b;
        return got;
    endfunction

    function automatic t_row step_row(input logic [7:0] b);
        t_row t;
        t       = '0;
        t.rx    = b;
        return t;
    endfunction

    function automatic t_row end_row(input logic [7:0] b, input logic [15:0] w1,
                                     input logic [15:0] w3, input logic st);
        t_row t;
        t.rx                = b;
        t.typed             = 1'b1;
        t.want.first_word   = w1;
        t.want.third_word   = w3;
        t.want.frame_status = st;
        return t;
    endfunction

    // Offers one byte, idling first at the configured rate, and predicts on transfer.
    task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                             input t_result want = '0);
        t_result r;
        bit      got;
        while ($urandom_range(99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= b;
        do @(posedge i_clk); while (!o_s_axis_tready);
        bytes_sent++;
        got = parse_byte(b, r);
        if (typed) pending_frames.push_back(want);
        else if (got) pending_frames.push_back(r);
    endtask

    // Builds a frame with the current headers; a broken frame is cut off early.
    task automatic send_frame(input logic [15:0] flen, input bit sum_ok, input bit hot,
                              input bit broken);
        logic [7:0]  fb[$];
        logic [15:0] s;
        int          total;
        int          n_out;
        fb.push_back(cfg_hdr1);
        fb.push_back(cfg_hdr2);
        fb.push_back(flen[15:8]);
        fb.push_back(flen[7:0]);
        total = (flen < 16'd4) ? 8 : int'(flen) + 4;
        while (fb.size() < total - 2)
            fb.push_back(hot ? 8'($urandom_range(255, 192)) : 8'($urandom));
        s = '0;
        foreach (fb[k]) s = s + 16'(fb[k]);
        if (!sum_ok) s = s ^ 16'($urandom_range(65535, 1));
        fb.push_back(s[15:8]);
        fb.push_back(s[7:0]);
        n_out = broken ? $urandom_range(total - 1, 3) : total;
        for (int k = 0; k < n_out; k++) send_byte(fb[k]);
    endtask

    // Mostly well-formed frames with random content, plus broken frames and noise.
    task automatic run_traffic(input int unsigned n);
        int unsigned stop;
        int unsigned pick;
        logic [15:0] flen;
        stop = bytes_sent + n;
        while (bytes_sent < stop) begin
            pick = $urandom_range(99);
            if (pick < 72) begin
                // Short lengths land checksum bytes on fixed slots or overrun.
                flen = ($urandom_range(9) == 0) ? 16'($urandom_range(9))
                                                : 16'($urandom_range(30, 4));
                send_frame(flen, $urandom_range(4) != 0, 1'b0, 1'b0);
            end else if (pick < 84) begin
                send_frame(16'($urandom_range(30, 4)), 1'b1, 1'b0, 1'b1);
            end else if (pick < 92) begin
                repeat ($urandom_range(4, 1)) send_byte(8'($urandom));
            end else begin
                send_byte(cfg_hdr1);
                if ($urandom_range(1)) send_byte(cfg_hdr2);
                send_byte(8'($urandom));
            end
        end
    endtask

    task automatic settle();
        i_s_axis_tvalid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_headers(input logic [7:0] h1, input logic [7:0] h2);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= CFG_HEADER_FIRST;
        i_cfg_data  <= h1;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_hdr1 = h1;
        i_cfg_index <= CFG_HEADER_SECOND;
        i_cfg_data  <= h2;
        do @(posedge i_clk); while (!o_cfg_ready);
        cfg_hdr2 = h2;
        i_cfg_valid <= 1'b0;
    endtask

    always @(posedge i_clk) begin : sink
        t_result want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            frames_seen++;
            if (pending_frames.size() == 0) begin
                note_error($sformatf("result %0d arrived with no frame pending", frames_seen));
            end else begin
                want = pending_frames.pop_front();
                if (o_m_axis_tdata[15:0] !== want.first_word)
                    note_error($sformatf("result %0d first_word %h, expected %h",
                                         frames_seen, o_m_axis_tdata[15:0], want.first_word));
                if (o_m_axis_tdata[31:16] !== want.third_word)
                    note_error($sformatf("result %0d third_word %h, expected %h",
                                         frames_seen, o_m_axis_tdata[31:16], want.third_word));
                if (o_m_axis_tuser[0] !== want.frame_status)
                    note_error($sformatf("result %0d frame_status %b, expected %b",
                                         frames_seen, o_m_axis_tuser[0], want.frame_status));
            end
        end
        // A hold-off request keeps the output stalled for a long, fixed stretch.
        if (hold_seen != hold_ask) begin
            hold_seen = hold_ask;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    initial begin : stimulus
        script = '{
            // Header pair at the length slot restarts the frame, then a good frame.
            step_row(8'h42), step_row(8'h4D), step_row(8'h42), step_row(8'h4D),
            step_row(8'h00), step_row(8'h04), step_row(8'h12), step_row(8'h34),
            step_row(8'h00), end_row(8'hD9, 16'h1234, 16'h0000, FRAME_OK),
            // All-ones data with a zero checksum.
            step_row(8'h42), step_row(8'h4D), step_row(8'h00), step_row(8'h04),
            step_row(8'hFF), step_row(8'hFF), step_row(8'h00),
            end_row(8'h00, 16'hFFFF, 16'h0000, FRAME_MISMATCH),
            // Wrong second header byte.
            step_row(8'h42), step_row(8'h00),
            // Zero length: the frame overruns and is dropped.
            step_row(8'h42), step_row(8'h4D), step_row(8'h00), step_row(8'h00),
            step_row(8'h5A), step_row(8'hA5), step_row(8'h3C)
        };
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Reset headers, no idling.
        foreach (script[k]) send_byte(script[k].rx, script[k].typed, script[k].want);
        run_traffic(160);
        settle();

        write_headers(8'h00, 8'hFF);
        src_idle_pct = 52;
        run_traffic(150);
        settle();

        write_headers(8'hFF, 8'h00);
        src_idle_pct  = 0;
        snk_stall_pct = 52;
        run_traffic(150);
        settle();

        write_headers(8'($urandom), 8'($urandom));
        src_idle_pct  = 28;
        snk_stall_pct = 28;
        run_traffic(150);
        settle();

        // Back-pressure: short frames keep coming while the output is held off.
        write_headers(HEADER_FIRST_RST, HEADER_SECOND_RST);
        src_idle_pct  = 0;
        snk_stall_pct = 0;
        hold_ask++;
        repeat (16) send_frame(16'd4, 1'b1, 1'b0, 1'b0);
        // A long frame of large bytes wraps the 16-bit sum.
        src_idle_pct  = 28;
        snk_stall_pct = 28;
        send_frame(16'd400, 1'b1, 1'b1, 1'b0);
        send_frame(16'd100, 1'b0, 1'b1, 1'b0);
        run_traffic(60);
        settle();

        $display("Sent %0d bytes under five header settings; checked %0d frame results.",
                 bytes_sent, frames_seen);
        $display("Phases covered idle input, stalled output, both, and a long output hold-off.");
        if (err_count == 0) begin
            $display("== PASS ==");
        end else begin
            $display("== FAIL ==");
        end
        $finish;
    end

endmodule

### files.f
hdl/pms_pkg.sv
hdl/pms_parser.sv
hdl/pms_out_fifo.sv
hdl/pms_frame_parser_top.sv
tb/pms_frame_parser_top_test.sv
